/* hw/rtl/daf_pkg.sv */
// Shared types and constants for the decimal ASCII formatter.
package daf_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned IN_W     = 6;
    localparam int unsigned CHAR_W   = 6;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NDIG_W   = 4;
    localparam int unsigned MAX_DIGS = 10;
    localparam int unsigned PROD_W   = 64;
    localparam int unsigned QUOT_LSB = 35;
    localparam int unsigned CLAMP_W  = 7;

    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic               KIND_PLAIN  = 1'b0;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic prep;
        logic emit;
    } daf_cmd_t;

    typedef struct packed {
        logic digits_needed;
        logic quot_zero;
        logic empty;
        logic out_free;
    } daf_sts_t;

endpackage

/* hw/rtl/daf_ctrl.sv */
// Sequencer for the formatter: accept, divide loop, pad setup, character output.
module daf_ctrl
    import daf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  daf_sts_t sts,
    output daf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_PREP,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.digits_needed ? ST_MUL : ST_PREP;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = sts.quot_zero ? ST_PREP : ST_MUL;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.emit = sts.out_free;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/daf_dp.sv */
// Datapath: divide-by-ten by reciprocal, digit stack, pad counter, output register.
module daf_dp
    import daf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [0:0] s_axis_tuser,   // [0] kind
    input  logic [39:0] s_axis_tdata,  // [31:0] value, [37:32] min_width, [39:38] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic       m_axis_tlast,
    input  daf_cmd_t   cmd,
    output daf_sts_t   sts
);

    localparam int unsigned PW = $clog2(MAX_WIDTH + 1);

    logic [VALUE_W-1:0]              value_reg;
    logic                            kind_reg;
    logic [PW-1:0]                   width_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic [MAX_DIGS-1:0][DIGIT_W-1:0] dig_reg;
    logic [NDIG_W-1:0]               ndig_reg;
    logic [PW-1:0]                   pad_reg;
    logic                            tvalid_reg;
    logic [CHAR_W-1:0]               char_reg;
    logic                            last_reg;

    logic [CLAMP_W-1:0]              width_in;
    logic [CLAMP_W-1:0]              width_clamped;
    logic [PROD_W-QUOT_LSB-1:0]      quot;
    logic [DIGIT_W-1:0]              quot_x10_lo;
    logic [DIGIT_W-1:0]              rem;
    logic [PW-1:0]                   pad_calc;
    logic [PW-1:0]                   ndig_ext;
    logic                            last_char;

    assign width_in      = CLAMP_W'(s_axis_tdata[37:32]);
    assign width_clamped = (width_in > CLAMP_W'(MAX_WIDTH)) ? CLAMP_W'(MAX_WIDTH) : width_in;

    // Quotient from the reciprocal product; low digit bits of q*10 give the remainder.
    assign quot        = prod_reg[PROD_W-1:QUOT_LSB];
    assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem         = value_reg[DIGIT_W-1:0] - quot_x10_lo;

    assign ndig_ext = PW'(ndig_reg);
    always_comb
    begin
        if (kind_reg == KIND_PLAIN)
        begin
            // Plain zero prints a lone '0'; plain negative prints nothing.
            // A positive value has been divided down to zero but holds its digits.
            pad_calc = (!value_reg[VALUE_W-1] && (value_reg == '0) && (ndig_reg == '0))
                       ? PW'(1) : '0;
        end
        else
        begin
            pad_calc = (width_reg > ndig_ext) ? (width_reg - ndig_ext) : '0;
        end
    end

    assign last_char = ((pad_reg == PW'(1)) && (ndig_reg == '0)) ||
                       ((pad_reg == '0) && (ndig_reg == NDIG_W'(1)));

    assign sts.digits_needed = !value_reg[VALUE_W-1] && (value_reg != '0);
    assign sts.quot_zero     = (quot == '0);
    assign sts.empty         = (pad_reg == '0) && (ndig_reg == '0);
    assign sts.out_free      = !tvalid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= s_axis_tdata[31:0];
            kind_reg  <= s_axis_tuser[0];
            width_reg <= PW'(width_clamped);
        end
        else if (cmd.div)
        begin
            value_reg <= VALUE_W'(quot);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(value_reg) * PROD_W'(DIV10_RECIP);
        end
    end

    // Digit stack: push the new low digit at the bottom, pop from the bottom.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg <= '0;
            pad_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ndig_reg <= '0;
                pad_reg  <= '0;
            end
            else if (cmd.div)
            begin
                ndig_reg <= ndig_reg + NDIG_W'(1);
            end
            else if (cmd.prep)
            begin
                pad_reg <= pad_calc;
            end
            else if (cmd.emit)
            begin
                if (pad_reg != '0)
                begin
                    pad_reg <= pad_reg - PW'(1);
                end
                else
                begin
                    ndig_reg <= ndig_reg - NDIG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div)
        begin
            dig_reg <= {dig_reg[MAX_DIGS-2:0], rem};
        end
        else if (cmd.emit && (pad_reg == '0))
        begin
            dig_reg <= {DIGIT_W'(0), dig_reg[MAX_DIGS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= (pad_reg != '0) ? ASCII_ZERO : (ASCII_ZERO + CHAR_W'(dig_reg[0]));
            last_reg <= last_char;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = {2'b00, char_reg};
    assign m_axis_tlast  = last_reg;

endmodule

/* hw/rtl/decimal_ascii_formatter.sv */
// Top level of the decimal ASCII formatter: sequencer plus datapath.
//
// Usage:
//   Input beats arrive on s_axis: s_axis_tdata carries the signed 32-bit value
//   in [31:0] and the minimum width in [37:32]; s_axis_tuser[0] selects plain
//   (0) or zero-padded (1) output. Each input produces zero or more output
//   beats on m_axis, one ASCII digit per beat in m_axis_tdata[5:0], most
//   significant first, with m_axis_tlast on the final character.
//   Plain mode: zero prints "0", negatives print nothing. Padded mode: leading
//   '0' fill up to min_width (clamped to MAX_WIDTH); zero or negative values
//   print exactly min_width zeros.
// Flow:
//   s_axis_tready is high only while idle. After acceptance the divide loop
//   runs a multiply state (the 32x32 reciprocal multiply) and then a divide
//   state (quotient/remainder) for each decimal digit, then a pad setup
//   state; then one character per cycle while m_axis is ready, and the
//   sequencer returns to idle after the final character.
// Reset and backpressure:
//   rst_n clears the sequencer, counters and output valid. When the receiver
//   stalls, the output register holds its beat and the character loop waits;
//   the next input can be accepted while the final character is still pending.
module decimal_ascii_formatter
    import daf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] min_width, [39:38] zero
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic        m_axis_tlast
);

    daf_cmd_t cmd;
    daf_sts_t sts;

    daf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    daf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

/* tb/sv/decimal_ascii_formatter_checker.sv */
// Checker for the decimal ASCII formatter: predicts each character beat and compares.
`timescale 1ns / 1ps

module daf_digit_checker
    import daf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] min_width, [39:38] zero
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          chars_owed
);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_beat_t;

    char_beat_t pending_chars[$];

    // Push the characters that one input beat must produce.
    function automatic void queue_digits_of(input logic kind,
                                            input logic signed [VALUE_W-1:0] value,
                                            input logic [IN_W-1:0] min_width);
        logic [DIGIT_W-1:0] digs [0:MAX_DIGS-1];
        logic [VALUE_W-1:0] rest;
        int                 ndig;
        int                 pad;
        int                 total;
        int                 n;
        int unsigned        width;
        char_beat_t         beat;
        ndig  = 0;
        pad   = 0;
        width = (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;
        if (value > 0)
        begin
            rest = value;
            while (rest != 0 && ndig < MAX_DIGS)
            begin
                digs[ndig] = DIGIT_W'(rest % 10);
                rest       = rest / 10;
                ndig++;
            end
        end
        if (kind == KIND_PLAIN)
        begin
            if (value < 0)
                return;
            if (value == 0)
            begin
                beat.character = ASCII_ZERO;
                beat.last      = 1'b1;
                pending_chars.push_back(beat);
                return;
            end
        end
        else if (int'(width) > ndig)
        begin
            pad = int'(width) - ndig;
        end
        total = pad + ndig;
        for (n = 0; n < total; n++)
        begin
            beat.character = (n < pad) ? ASCII_ZERO
                                       : ASCII_ZERO + CHAR_W'(digs[total - 1 - n]);
            beat.last      = (n == total - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t want;
        if (!rst_n)
        begin
            pending_chars.delete();
            mismatches = 0;
            chars_owed = 0;
        end
        else
        begin
            // Compare before predicting so a beat never matches an item taken at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("character beat 0x%0h with no expected character", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_axis_tdata[CHAR_W-1:0] !== want.character)
                    begin
                        $error("character: expected %0d, got %0d",
                               want.character, m_axis_tdata[CHAR_W-1:0]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:CHAR_W] !== '0)
                    begin
                        $error("tdata pad: expected 0, got %0h", m_axis_tdata[7:CHAR_W]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                queue_digits_of(s_axis_tuser[0], s_axis_tdata[VALUE_W-1:0],
                                s_axis_tdata[VALUE_W +: IN_W]);
            chars_owed = pending_chars.size();
        end
    end

endmodule

/* tb/sv/decimal_ascii_formatter_tb.sv */
// Testbench top for the decimal ASCII formatter: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module decimal_ascii_formatter_tb;
    import daf_pkg::*;

    localparam int unsigned WIDTH_LIMIT = 32;
    localparam logic        KIND_PADDED = ~KIND_PLAIN;
    localparam int          IDLE_LIMIT  = 2000;   // cycles with no beat on either side
    localparam int          SETTLE      = 40;     // longest digit loop plus margin
    localparam int          RANDOM_ITEMS = 390;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // [31:0] value, [37:32] min_width, [39:38] zero
    logic [0:0]  s_axis_tuser;    // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [5:0] character, [7:6] zero
    logic        m_axis_tlast;

    int          mismatches;
    int          chars_owed;
    int          idle_cycles;
    // When set, both sides run back to back with no gaps.
    logic        quiet;

    decimal_ascii_formatter #(.MAX_WIDTH(WIDTH_LIMIT)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    daf_digit_checker #(.MAX_WIDTH(WIDTH_LIMIT)) char_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .chars_owed    (chars_owed)
    );

    // 20 ns clock, high then low.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Draw the wait before one beat; none during a quiet stretch.
    function automatic int beat_gap();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Drive one input beat at the falling edge and hold it until the block takes it.
    // Valid stays high between back-to-back beats, so it is never dropped and raised in one step.
    task automatic send_value(input logic kind, input logic signed [31:0] value,
                              input logic [5:0] min_width);
        int gap;
        gap = beat_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, min_width, value};
        s_axis_tuser  = kind;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Pick a value that spreads over digit counts, decade edges, zero and negatives.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] decade;
        int                 k;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2:
            begin
                k      = $urandom_range(0, 9);
                decade = 1;
                repeat (k) decade = decade * 10;
                return decade + $urandom_range(0, 2) - 1;
            end
            3: return $urandom_range(0, 1) ? -$signed($urandom_range(1, 1000))
                                            : $signed(32'h8000_0000 | $urandom);
            4: return 0;
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    // Receiver: draw a stall for every character beat, then hold ready until the beat moves.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = beat_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        int min_w;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PLAIN;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: plain zero, single digits, decade edges, extremes and negatives.
        send_value(KIND_PLAIN,  32'sd0,           6'd0);
        send_value(KIND_PLAIN,  32'sd1,           6'd0);
        send_value(KIND_PLAIN,  32'sd9,           6'd0);
        send_value(KIND_PLAIN,  32'sd10,          6'd0);
        send_value(KIND_PLAIN,  32'sd1000000000,  6'd63);   // width ignored when plain
        send_value(KIND_PLAIN,  32'sh7FFF_FFFF,   6'd5);
        send_value(KIND_PLAIN,  -32'sd1,          6'd0);
        send_value(KIND_PLAIN,  32'sh8000_0000,   6'd32);
        send_value(KIND_PLAIN,  32'sd0,           6'd63);
        // Padded zero and negatives: exactly min_width zeros, nothing for width zero.
        send_value(KIND_PADDED, 32'sd0,           6'd0);
        send_value(KIND_PADDED, 32'sd0,           6'd5);
        send_value(KIND_PADDED, -32'sd7,          6'd0);
        send_value(KIND_PADDED, -32'sd7,          6'd32);
        send_value(KIND_PADDED, 32'sh8000_0000,   6'd63);   // saturates to the limit
        // Padded positives: digits already wide enough, real pad, full width.
        send_value(KIND_PADDED, 32'sd7,           6'd1);
        send_value(KIND_PADDED, 32'sd12345,       6'd3);
        send_value(KIND_PADDED, 32'sd42,          6'd32);
        send_value(KIND_PADDED, 32'sh7FFF_FFFF,   6'd10);
        send_value(KIND_PADDED, 32'sh7FFF_FFFF,   6'd0);
        send_value(KIND_PADDED, 32'sd1,           6'd33);
        send_value(KIND_PADDED, 32'sd999,         6'd63);
        send_value(KIND_PADDED, 32'sd1000000000,  6'd11);
        send_value(KIND_PADDED, 32'sh7FFF_FFFF,   6'd48);

        // Random: mostly narrow widths to keep the run short, some across the full field.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 30 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            min_w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, 12);
            send_value($urandom_range(0, 1) ? KIND_PADDED : KIND_PLAIN, pick_value(),
                       6'(min_w));
        end

        // Drop valid, drain every owed character, then let the block settle.
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (chars_owed != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/daf_pkg.sv
hw/rtl/daf_ctrl.sv
hw/rtl/daf_dp.sv
hw/rtl/decimal_ascii_formatter.sv
tb/sv/decimal_ascii_formatter_checker.sv
tb/sv/decimal_ascii_formatter_tb.sv
